>>> design/assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> design/akx_pkg.sv
package akx_pkg;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int KSIZE_W  = 2;
    localparam int COUNT_W  = 4;
    localparam int POS_W    = 3;
    localparam int WIN_DEPTH = 8;

    localparam logic [KSIZE_W-1:0] KSIZE_128 = 2'd0;
    localparam logic [KSIZE_W-1:0] KSIZE_192 = 2'd1;
    localparam logic [KSIZE_W-1:0] KSIZE_256 = 2'd2;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] XTIME_POLY = 8'h1b;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXPAND
    } akx_state_t;

    typedef struct packed {
        logic                 load;
        logic [POS_W-1:0]     load_idx;
        logic                 init;
        logic                 exp_en;
        logic [POS_W-1:0]     pos;
        logic                 copy;
        logic                 rot_sub;
        logic                 sub_only;
        logic [INDEX_W-1:0]   idx;
        logic                 last;
    } akx_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        logic [7:0] s;
        s = {b[6:0], 1'b0};
        return b[7] ? (s ^ XTIME_POLY) : s;
    endfunction

    function automatic logic [COUNT_W-1:0] key_nk(input logic [KSIZE_W-1:0] ks);
        logic [COUNT_W-1:0] nk;
        unique case (ks)
            KSIZE_128: nk = 4'd4;
            KSIZE_192: nk = 4'd6;
            default:   nk = 4'd8;
        endcase
        return nk;
    endfunction

endpackage

>>> design/akx_ctrl.sv
`include "assert_macros.svh"

module akx_ctrl
    import akx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cfg_valid,
    input  logic [KSIZE_W-1:0] cfg_data,
    output logic               busy,
    output akx_cmd_t           cmd
);

    akx_state_t          state_reg, state_next;
    logic [KSIZE_W-1:0]  key_size_reg;
    logic [COUNT_W-1:0]  loaded_count_reg, loaded_count_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COUNT_W-1:0]  nk;
    logic [INDEX_W-1:0]  last_idx;
    logic                restart;
    logic [COUNT_W-1:0]  count_inc;

    assign nk       = key_nk(key_size_reg);
    // total words = 4*(nk+7); last index = 4*nk + 27
    assign last_idx = {nk, 2'b00} + INDEX_W'(27);
    assign restart  = (loaded_count_reg >= nk);
    assign count_inc = restart ? COUNT_W'(1) : loaded_count_reg + COUNT_W'(1);
    assign busy     = (state_reg == ST_EXPAND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_size_reg     <= KSIZE_128;
            loaded_count_reg <= '0;
            idx_reg          <= '0;
            pos_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            idx_reg          <= idx_next;
            pos_reg          <= pos_next;
            if (cfg_valid)
            begin
                key_size_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        cmd               = '0;
        cmd.pos           = pos_reg;
        cmd.idx           = idx_reg;
        cmd.load_idx      = restart ? '0 : loaded_count_reg[POS_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (count_inc == nk)
                    begin
                        cmd.init          = 1'b1;
                        loaded_count_next = '0;
                        idx_next          = '0;
                        pos_next          = '0;
                        state_next        = ST_EXPAND;
                    end
                    else
                    begin
                        loaded_count_next = count_inc;
                    end
                end
            end
            ST_EXPAND:
            begin
                cmd.exp_en   = 1'b1;
                cmd.copy     = (INDEX_W'(nk) > idx_reg);
                cmd.rot_sub  = !cmd.copy && (pos_reg == '0);
                cmd.sub_only = !cmd.copy && (nk == 4'd8) && (pos_reg == POS_W'(4));
                cmd.last     = (idx_reg == last_idx);
                idx_next     = idx_reg + INDEX_W'(1);
                pos_next     = (COUNT_W'(pos_reg) == nk - COUNT_W'(1)) ? '0
                             : pos_reg + POS_W'(1);
                if (cmd.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEVER(a_pos_range, clk, rst_n, busy && (COUNT_W'(pos_reg) >= nk), "pos out of range")
    `ASSERT_PROP(a_last_ends, clk, rst_n, (busy && cmd.last) |=> !busy, "expand did not end")
    `ASSERT_NEVER(a_load_count, clk, rst_n, loaded_count_reg >= COUNT_W'(WIN_DEPTH), "count overran window")

endmodule

>>> design/akx_datapath.sv
module akx_datapath
    import akx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  akx_cmd_t           cmd,
    input  logic [WORD_W-1:0]  key_word,
    output logic [WORD_W-1:0]  round_key_word,
    output logic [INDEX_W-1:0] word_index,
    output logic               last_word,
    output logic               word_valid
);

    logic [WORD_W-1:0]  window_reg [WIN_DEPTH];
    logic [WORD_W-1:0]  prev_reg;
    logic [7:0]         rcon_reg, rcon_next;
    logic [WORD_W-1:0]  out_word_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic               out_last_reg;
    logic               valid_reg;

    logic [WORD_W-1:0]  old_word;
    logic [WORD_W-1:0]  sub_in;
    logic [WORD_W-1:0]  sub_out;
    logic [WORD_W-1:0]  temp;
    logic [WORD_W-1:0]  new_word;

    assign old_word = window_reg[cmd.pos];
    assign sub_in   = cmd.rot_sub ? {prev_reg[23:0], prev_reg[31:24]} : prev_reg;
    assign sub_out  = sub_word(sub_in);

    always_comb
    begin
        if (cmd.rot_sub)
        begin
            temp = sub_out ^ {rcon_reg, 24'h0};
        end
        else if (cmd.sub_only)
        begin
            temp = sub_out;
        end
        else
        begin
            temp = prev_reg;
        end
        new_word  = cmd.copy ? old_word : (old_word ^ temp);
        rcon_next = rcon_reg;
        if (cmd.init)
        begin
            rcon_next = RCON_INIT;
        end
        else if (cmd.exp_en && cmd.rot_sub)
        begin
            rcon_next = xtime(rcon_reg);
        end
    end

    // window slot i mod nk holds w[i-nk] until w[i] replaces it
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            window_reg[cmd.load_idx] <= key_word;
        end
        else if (cmd.exp_en)
        begin
            window_reg[cmd.pos] <= new_word;
        end
        if (cmd.exp_en)
        begin
            prev_reg     <= new_word;
            out_word_reg <= new_word;
            out_idx_reg  <= cmd.idx;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg  <= RCON_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            rcon_reg  <= rcon_next;
            valid_reg <= cmd.exp_en;
        end
    end

    assign round_key_word = out_word_reg;
    assign word_index     = out_idx_reg;
    assign last_word      = out_last_reg;
    assign word_valid     = valid_reg;

endmodule

>>> design/aes_key_expansion_top.sv
// Key words load one per cycle while busy is low; no beat comes out until the Nk-th.
// The Nk-th beat starts expansion: the controller enters its expand state, where word 0 is
// computed and registered to the output, then one word per cycle, 44/52/60 beats, busy high throughout.
// Results cannot be stalled. Async active-low reset: idle, no partial key, 128-bit size.
module aes_key_expansion_top
    import akx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [WORD_W-1:0]  key_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [KSIZE_W-1:0] cfg_data,
    output logic               word_valid,
    output logic [WORD_W-1:0]  round_key_word,
    output logic [INDEX_W-1:0] word_index,
    output logic               last_word
);

    akx_cmd_t cmd;

    assign cfg_ready = 1'b1;

    akx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd       (cmd)
    );

    akx_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .key_word       (key_word),
        .round_key_word (round_key_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .word_valid     (word_valid)
    );

endmodule

>>> tb/sv/akx_checker.sv
module akx_checker
    import akx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [WORD_W-1:0]  key_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [KSIZE_W-1:0] cfg_data,
    input  logic               word_valid,
    input  logic [WORD_W-1:0]  round_key_word,
    input  logic [INDEX_W-1:0] word_index,
    input  logic               last_word,
    output int                 mismatches,
    output int                 pending,
    output int                 words_checked,
    output int                 schedules
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] idx;
        logic               last;
    } sched_word_t;

    sched_word_t        schedule_q[$];
    logic [7:0]         sbox_tbl [256];
    logic [KSIZE_W-1:0] size_reg;
    logic [COUNT_W-1:0] words_loaded;
    logic [WORD_W-1:0]  key_window [WIN_DEPTH];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                p ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // multiplicative inverse in GF(2^8), then the affine map
    function automatic logic [7:0] sbox_entry(input logic [7:0] b);
        logic [7:0] inv;
        inv = 8'h00;
        for (int x = 1; x < 256; x++)
        begin
            if (gf_mul(b, 8'(x)) == 8'h01)
                inv = 8'(x);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                   ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] w);
        return {sbox_tbl[w[31:24]], sbox_tbl[w[23:16]], sbox_tbl[w[15:8]], sbox_tbl[w[7:0]]};
    endfunction

    function automatic int words_per_key(input logic [KSIZE_W-1:0] ks);
        case (ks)
            KSIZE_128: return 4;
            KSIZE_192: return 6;
            default:   return 8;
        endcase
    endfunction

    task automatic load_key_word(input logic [WORD_W-1:0] w);
        int                nk;
        int                total;
        logic [WORD_W-1:0] sched [60];
        logic [WORD_W-1:0] t;
        logic [7:0]        rcon;
        nk = words_per_key(size_reg);
        if (words_loaded >= nk)
            words_loaded = '0;
        key_window[words_loaded[POS_W-1:0]] = w;
        words_loaded = words_loaded + 1'b1;
        if (words_loaded == nk)
        begin
            total = 4 * (nk + 7);
            rcon = RCON_INIT;
            for (int i = 0; i < total; i++)
            begin
                if (i < nk)
                    sched[i] = key_window[i];
                else
                begin
                    t = sched[i-1];
                    if (i % nk == 0)
                    begin
                        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h000000};
                        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
                    end
                    else if (nk == 8 && i % nk == 4)
                        t = sbox_word(t);
                    sched[i] = sched[i-nk] ^ t;
                end
                schedule_q.push_back(sched_word_t'{sched[i], INDEX_W'(i), i == total - 1});
            end
            words_loaded = '0;
            schedules++;
        end
    endtask

    initial
    begin
        for (int b = 0; b < 256; b++)
            sbox_tbl[b] = sbox_entry(8'(b));
        mismatches = 0;
        pending = 0;
        words_checked = 0;
        schedules = 0;
        size_reg = KSIZE_128;
        words_loaded = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        sched_word_t exp_w;
        if (!rst_n)
        begin
            size_reg = KSIZE_128;
            words_loaded = '0;
            schedule_q.delete();
            pending = 0;
        end
        else
        begin
            if (word_valid)
            begin
                if (schedule_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat, round_key_word %h word_index %0d",
                             $time, round_key_word, word_index);
                end
                else
                begin
                    exp_w = schedule_q.pop_front();
                    words_checked++;
                    if (round_key_word !== exp_w.word)
                    begin
                        mismatches++;
                        $display("%0t: w[%0d] round_key_word expected %h, got %h",
                                 $time, exp_w.idx, exp_w.word, round_key_word);
                    end
                    if (word_index !== exp_w.idx)
                    begin
                        mismatches++;
                        $display("%0t: word_index expected %0d, got %0d",
                                 $time, exp_w.idx, word_index);
                    end
                    if (last_word !== exp_w.last)
                    begin
                        mismatches++;
                        $display("%0t: w[%0d] last_word expected %0b, got %0b",
                                 $time, exp_w.idx, exp_w.last, last_word);
                    end
                end
            end
            if (start && !busy)
                load_key_word(key_word);
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            pending = schedule_q.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import akx_pkg::*;

    localparam logic [KSIZE_W-1:0] KSIZE_SPARE = 2'd3;
    localparam int ITEM_TARGET   = 360;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [WORD_W-1:0]  key_word = '0;
    logic               cfg_valid = 1'b0;
    logic [KSIZE_W-1:0] cfg_data = '0;
    logic               busy;
    logic               cfg_ready;
    logic               word_valid;
    logic [WORD_W-1:0]  round_key_word;
    logic [INDEX_W-1:0] word_index;
    logic               last_word;

    int mismatches;
    int pending;
    int words_checked;
    int schedules;
    int items_sent = 0;
    int cycles = 0;
    int size_writes [4] = '{0, 0, 0, 0};

    aes_key_expansion_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key_word       (key_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .word_valid     (word_valid),
        .round_key_word (round_key_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    akx_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key_word       (key_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .word_valid     (word_valid),
        .round_key_word (round_key_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .mismatches     (mismatches),
        .pending        (pending),
        .words_checked  (words_checked),
        .schedules      (schedules)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d round key words still outstanding", $time, pending);
            $display("[aes_key_expansion_top] ERROR");
            $finish;
        end
    end

    // one beat per accepted key word; start stays high across back-to-back words
    task automatic send_key_word(input logic [WORD_W-1:0] w, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        key_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_key_size(input logic [KSIZE_W-1:0] ks);
        cfg_valid <= 1'b1;
        cfg_data <= ks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_writes[ks]++;
    endtask

    task automatic drain_schedule();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_key_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_key(input int count, input bit no_gaps);
        for (int k = 0; k < count; k++)
            send_key_word(pick_key_word(), no_gaps ? 0 : $urandom_range(0, 15));
    endtask

    initial
    begin
        logic [WORD_W-1:0]  fips_key [8];
        logic [KSIZE_W-1:0] ks;
        int                 nk;
        int                 part;
        bit                 no_gaps;

        fips_key = '{32'h603deb10, 32'h15ca71be, 32'h2b73aef0, 32'h857d7781,
                     32'h1f352c07, 32'h3b6108d7, 32'h2d9810a3, 32'h0914dff4};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_key_size(KSIZE_128);
        for (int k = 0; k < 4; k++)
            send_key_word('0, 0);
        drain_schedule();

        write_key_size(KSIZE_192);
        for (int k = 0; k < 6; k++)
            send_key_word('1, $urandom_range(0, 15));
        drain_schedule();

        // spare size code behaves as 256-bit
        write_key_size(KSIZE_SPARE);
        for (int k = 0; k < 8; k++)
            send_key_word(fips_key[k], 0);
        drain_schedule();

        // shrink mid-load past the new Nk: next word restarts the key
        write_key_size(KSIZE_256);
        load_key(5, 0);
        drain_schedule();
        write_key_size(KSIZE_128);
        load_key(4, 0);
        drain_schedule();

        while (items_sent < ITEM_TARGET)
        begin
            ks = KSIZE_W'($urandom_range(0, 3));
            nk = (ks == KSIZE_128) ? 4 : (ks == KSIZE_192) ? 6 : 8;
            no_gaps = ($urandom_range(0, 3) == 0);
            write_key_size(ks);
            if ($urandom_range(0, 5) == 0)
            begin
                part = $urandom_range(1, nk - 1);
                load_key(part, no_gaps);
                drain_schedule();
                ks = KSIZE_W'($urandom_range(0, 3));
                nk = (ks == KSIZE_128) ? 4 : (ks == KSIZE_192) ? 6 : 8;
                write_key_size(ks);
                load_key((part >= nk) ? nk : nk - part, no_gaps);
            end
            else
                load_key(nk, no_gaps);
            drain_schedule();
        end

        drain_schedule();
        $display("run covered %0d key words and %0d schedules, %0d round key words checked",
                 items_sent, schedules, words_checked);
        $display("key size writes 128/192/256/spare: %0d/%0d/%0d/%0d",
                 size_writes[0], size_writes[1], size_writes[2], size_writes[3]);
        if (mismatches == 0 && pending == 0)
            $display("[aes_key_expansion_top] OK");
        else
        begin
            if (pending != 0)
                $display("%0t: %0d round key words never came out", $time, pending);
            $display("[aes_key_expansion_top] ERROR");
        end
        $finish;
    end

endmodule
